### rtl/core/pec_pkg.sv
// Shared types, widths and helpers for the polynomial evaluation unit.
// No dependencies; every other file of the block refers to it by scoped name.
package pec_pkg;

   localparam int NUM_COEFFS_DEF = 7;   // degree six polynomial
   localparam int FRAC_BITS_DEF  = 16;  // Q16.16

   localparam int DATA_W    = 32;       // coefficients, time point, results
   localparam int CSR_IDX_W = 3;        // register index width
   localparam int LANES     = 4;        // value and three derivatives
   localparam int ACC_W     = 63;       // Horner accumulator
   localparam int SCALE_W   = 39;       // coef times falling factorial (<= 120)
   localparam int PROD_W    = ACC_W + DATA_W;  // exact acc * t
   localparam int SUM_W     = ACC_W + 1;       // acc + scaled coef

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // One derivative lane between Horner steps.
   typedef struct packed {
      logic [ACC_W-1:0] acc;
      logic             sat;
   } lane_type;

   // i * (i-1) * ... * (i-k+1); zero when i < k.
   function automatic int falling(input int i, input int k);
      int r;
      r = 1;
      for (int j = 0; j < k; j++) begin
         r = r * (i - j);
      end
      return r;
   endfunction

endpackage

### rtl/core/pec_coef_regs.sv
// Coefficient registers, stored premultiplied by the falling factorial of each
// derivative order. Depends on pec_pkg.
module pec_coef_regs #(
   parameter int NUM_COEFFS = pec_pkg::NUM_COEFFS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [pec_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pec_pkg::DATA_W-1:0]            csr_wdata,
   output logic signed [pec_pkg::SCALE_W-1:0]    scale [pec_pkg::LANES][NUM_COEFFS]
);

   logic signed [pec_pkg::SCALE_W-1:0] scale_ff [pec_pkg::LANES][NUM_COEFFS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < pec_pkg::LANES; k++) begin
            for (int i = 0; i < NUM_COEFFS; i++) begin
               scale_ff[k][i] <= '0;
            end
         end
      end else if (csr_wr_en) begin
         for (int i = 0; i < NUM_COEFFS; i++) begin
            if (csr_index == pec_pkg::CSR_IDX_W'(i)) begin
               for (int k = 0; k < pec_pkg::LANES; k++) begin
                  scale_ff[k][i] <= pec_pkg::SCALE_W'($signed(csr_wdata))
                                  * pec_pkg::SCALE_W'(pec_pkg::falling(i, k));
               end
            end
         end
      end
   end

   assign scale = scale_ff;

endmodule

### rtl/core/pec_step.sv
// One Horner step for one lane: acc <= sat(floor(acc * t / 2^F)) + coef.
// Four register stages. Depends on pec_pkg.
module pec_step #(
   parameter int FRAC_BITS = pec_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                adv,
   input  logic signed [pec_pkg::DATA_W-1:0]   time_point,
   input  logic signed [pec_pkg::SCALE_W-1:0]  coef,
   input  pec_pkg::lane_type                   lane_in,
   output pec_pkg::lane_type                   lane_out
);

   localparam int ACC_W  = pec_pkg::ACC_W;
   localparam int PROD_W = pec_pkg::PROD_W;
   localparam int SUM_W  = pec_pkg::SUM_W;
   localparam int HALF   = pec_pkg::DATA_W;

   localparam logic signed [PROD_W-1:0] POS_LIM =
      $signed(PROD_W'(1)) <<< (ACC_W - 1 + FRAC_BITS);
   localparam logic signed [PROD_W-1:0] NEG_LIM = -POS_LIM;

   // stage 1: partial products
   logic signed [HALF+HALF:0]        plo_ff, plo_in;
   logic signed [ACC_W-1:0]          phi_ff, phi_in;
   logic                             sat1_ff;
   // stage 2: full product
   logic signed [PROD_W-1:0]         prod_ff, prod_in;
   logic                             sat2_ff;
   // stage 3: scale, clamp, add
   logic signed [PROD_W-1:0]         shifted;
   logic                             pos_clip, neg_clip;
   logic signed [ACC_W-1:0]          mac;
   logic signed [SUM_W-1:0]          sum_ff, sum_in;
   logic                             sat3_ff, sat3_in;
   // stage 4: clamp to accumulator range
   logic                             over;
   pec_pkg::lane_type                lane_ff, lane_in_next;

   always_comb begin
      plo_in = $signed({1'b0, lane_in.acc[HALF-1:0]}) * time_point;
      phi_in = $signed(lane_in.acc[ACC_W-1:HALF]) * time_point;
      prod_in = (PROD_W'(phi_ff) <<< HALF) + PROD_W'(plo_ff);

      // magnitude at or past 2^(62+F) counts as a clip in either sign
      shifted  = prod_ff >>> FRAC_BITS;
      pos_clip = prod_ff >= POS_LIM;
      neg_clip = prod_ff <= NEG_LIM;
      if (pos_clip) begin
         mac = pec_pkg::ACC_MAX;
      end else if (neg_clip) begin
         mac = pec_pkg::ACC_MIN;
      end else begin
         mac = shifted[ACC_W-1:0];
      end
      sum_in  = SUM_W'(mac) + SUM_W'(coef);
      sat3_in = sat2_ff | pos_clip | neg_clip;

      over = sum_ff[SUM_W-1] != sum_ff[SUM_W-2];
      lane_in_next.sat = sat3_ff | over;
      if (over) begin
         lane_in_next.acc = sum_ff[SUM_W-1] ? pec_pkg::ACC_MIN : pec_pkg::ACC_MAX;
      end else begin
         lane_in_next.acc = sum_ff[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         sat1_ff <= lane_in.sat;
         prod_ff <= prod_in;
         sat2_ff <= sat1_ff;
         sum_ff  <= sum_in;
         sat3_ff <= sat3_in;
         lane_ff <= lane_in_next;
      end
   end

   assign lane_out = lane_ff;

endmodule

### rtl/core/polynomial_eval_with_derivatives_unit.sv
// Top level of the polynomial evaluation unit: p(t), p'(t), p''(t), p'''(t).
// Depends on pec_pkg, pec_coef_regs and pec_step.
//
//   channel  dir  handshake             payload
//   -------  ---  --------------------  -------------------------------------------
//   req      in   req_valid/req_stall   req_time_point (signed Q16.16)
//   rsp      out  rsp_valid/rsp_stall   rsp_position, rsp_velocity,
//                                       rsp_acceleration, rsp_jerk_value,
//                                       rsp_saturated
//   csr      in   csr_wr_en             csr_index, csr_wdata (coef_0..coef_6)
//
// One item per cycle sustained while the output register is not stalled. The
// pipeline is an entry register, four stages per Horner step, an output register.
// Each Horner step is one 33x32 and one 31x32 multiply, a 95-bit product add,
// then clamp and coefficient add, then clamp to 63 bits.
// Synchronous reset empties the pipeline and zeroes all coefficients.
// The whole pipeline holds while the output register has an item not yet taken;
// empty slots move along with the items and are never squeezed out.
module polynomial_eval_with_derivatives_unit #(
   parameter int NUM_COEFFS = pec_pkg::NUM_COEFFS_DEF,
   parameter int FRAC_BITS  = pec_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // item in
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [pec_pkg::DATA_W-1:0]  req_time_point,
   // item out
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [pec_pkg::DATA_W-1:0]  rsp_position,
   output logic signed [pec_pkg::DATA_W-1:0]  rsp_velocity,
   output logic signed [pec_pkg::DATA_W-1:0]  rsp_acceleration,
   output logic signed [pec_pkg::DATA_W-1:0]  rsp_jerk_value,
   output logic                               rsp_saturated,
   // coefficient writes
   input  logic                               csr_wr_en,
   input  logic [pec_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pec_pkg::DATA_W-1:0]         csr_wdata
);

   localparam int TOP    = NUM_COEFFS - 1;      // Horner steps per lane
   localparam int STAGES = 4 * TOP;
   localparam int LANES  = pec_pkg::LANES;
   localparam int DW     = pec_pkg::DATA_W;
   localparam int ACC_W  = pec_pkg::ACC_W;

   logic adv;   // pipeline moves this cycle

   logic signed [pec_pkg::SCALE_W-1:0] scale [LANES][NUM_COEFFS];

   logic                       v_ff [0:STAGES];
   logic signed [DW-1:0]       t_ff [0:STAGES-4];
   pec_pkg::lane_type          lane_w [0:TOP][LANES];

   logic                       rsp_valid_ff;
   logic signed [DW-1:0]       res_in [LANES];
   logic signed [DW-1:0]       res_ff [LANES];
   logic                       sat_in, sat_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   pec_coef_regs #(
      .NUM_COEFFS (NUM_COEFFS)
   ) u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .scale     (scale)
   );

   // valid bits and time point travel alongside the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= STAGES; j++) begin
            v_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int j = 1; j <= STAGES; j++) begin
            v_ff[j] <= v_ff[j-1];
         end
      end
   end

   // t is only needed up to the first stage of the last Horner step
   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff[0] <= req_time_point;
         for (int j = 1; j <= STAGES - 4; j++) begin
            t_ff[j] <= t_ff[j-1];
         end
      end
   end

   // Lane k runs Horner over e_j = falling(j+k,k)*c[j+k], padded with leading
   // zeros so every lane takes the same TOP steps. Only lane 0 starts nonzero.
   // Users must change coefficients only while the pipeline is empty (unenforced).
   generate
      for (genvar k = 0; k < LANES; k++) begin : g_entry
         if (k == 0) begin : g_lead
            assign lane_w[0][k].acc = ACC_W'(scale[0][TOP]);
         end else begin : g_zero
            assign lane_w[0][k].acc = '0;
         end
         assign lane_w[0][k].sat = 1'b0;
      end

      for (genvar s = 0; s < TOP; s++) begin : g_step
         for (genvar k = 0; k < LANES; k++) begin : g_lane
            logic signed [pec_pkg::SCALE_W-1:0] step_coef;
            if (TOP - 1 - s + k <= TOP) begin : g_coef
               assign step_coef = scale[k][TOP-1-s+k];
            end else begin : g_pad
               assign step_coef = '0;
            end

            pec_step #(
               .FRAC_BITS (FRAC_BITS)
            ) u_step (
               .clock      (clock),
               .adv        (adv),
               .time_point (t_ff[4*s]),
               .coef       (step_coef),
               .lane_in    (lane_w[s][k]),
               .lane_out   (lane_w[s+1][k])
            );
         end
      end
   endgenerate

   // final clip to 32 bits
   always_comb begin
      logic [ACC_W-1:0] acc;
      logic             over;
      sat_in = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         acc  = lane_w[TOP][k].acc;
         over = !((&acc[ACC_W-1:DW-1]) || !(|acc[ACC_W-1:DW-1]));
         if (over) begin
            res_in[k] = acc[ACC_W-1] ? pec_pkg::DATA_MIN : pec_pkg::DATA_MAX;
         end else begin
            res_in[k] = acc[DW-1:0];
         end
         sat_in = sat_in | over | lane_w[TOP][k].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv && v_ff[STAGES]) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = res_ff[0];
   assign rsp_velocity     = res_ff[1];
   assign rsp_acceleration = res_ff[2];
   assign rsp_jerk_value   = res_ff[3];
   assign rsp_saturated    = sat_ff;

endmodule

### rtl/core/pec_checker.sv
// Port-level checks for the polynomial evaluation unit, bound to the top level.
// Depends on pec_pkg and polynomial_eval_with_derivatives_unit.
module pec_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [pec_pkg::DATA_W-1:0] rsp_position,
   input logic signed [pec_pkg::DATA_W-1:0] rsp_velocity,
   input logic signed [pec_pkg::DATA_W-1:0] rsp_acceleration,
   input logic signed [pec_pkg::DATA_W-1:0] rsp_jerk_value,
   input logic                              rsp_saturated
);

   // a result held back stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position)
         && $stable(rsp_velocity) && $stable(rsp_acceleration)
         && $stable(rsp_jerk_value) && $stable(rsp_saturated))
      else $error("rsp item changed while stalled");

   // input is held back only by a blocked output register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled with free output register");

   // a draining output lets the next item in
   a_drain_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |-> !req_stall)
      else $error("req stalled while rsp item taken");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind polynomial_eval_with_derivatives_unit pec_checker u_pec_checker (.*);

### test/motion_checker.sv
// Checker for the polynomial evaluation unit: tracks coefficient writes,
// predicts every response from the accepted time point and compares it.
// Depends on pec_pkg for widths and default parameters.
module motion_checker #(
   parameter int NUM_COEFFS = pec_pkg::NUM_COEFFS_DEF,
   parameter int FRAC_BITS  = pec_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic signed [pec_pkg::DATA_W-1:0]  req_time_point,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [pec_pkg::DATA_W-1:0]  rsp_position,
   input  logic signed [pec_pkg::DATA_W-1:0]  rsp_velocity,
   input  logic signed [pec_pkg::DATA_W-1:0]  rsp_acceleration,
   input  logic signed [pec_pkg::DATA_W-1:0]  rsp_jerk_value,
   input  logic                               rsp_saturated,
   input  logic                               csr_wr_en,
   input  logic [pec_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pec_pkg::DATA_W-1:0]         csr_wdata,
   output int                                 mismatch_count,
   output int                                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COEF_SLOTS = 7;
   localparam int ACC_BITS   = 63;

   // wide enough for the exact product of a 63-bit accumulator and t
   typedef logic signed [94:0] wide_type;

   localparam wide_type ACC_HI  = (wide_type'(1) <<< (ACC_BITS - 1)) - 1;
   localparam wide_type ACC_LO  = -(wide_type'(1) <<< (ACC_BITS - 1));
   localparam wide_type OUT_HI  = (wide_type'(1) <<< (pec_pkg::DATA_W - 1)) - 1;
   localparam wide_type OUT_LO  = -(wide_type'(1) <<< (pec_pkg::DATA_W - 1));
   localparam wide_type MUL_SAT = wide_type'(1) <<< (ACC_BITS - 1 + FRAC_BITS);

   typedef struct packed {
      logic        clipped;
      logic [31:0] value;
   } lane_out_type;

   typedef struct packed {
      logic [31:0] position;
      logic [31:0] velocity;
      logic [31:0] acceleration;
      logic [31:0] jerk_value;
      logic        saturated;
   } motion_type;

   logic signed [31:0] coef_bank [COEF_SLOTS];
   motion_type         motion_due [$];

   function automatic int falling_factor(input int power, input int order);
      int r;
      r = 1;
      for (int j = 0; j < order; j++) r = r * (power - j);
      return r;
   endfunction

   function automatic bit clip_range(inout wide_type v, input wide_type lo,
                                     input wide_type hi);
      if (v > hi) begin
         v = hi;
         return 1'b1;
      end
      if (v < lo) begin
         v = lo;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Horner over the coefficients scaled for derivative order `order`
   function automatic lane_out_type eval_lane(input int order, input logic signed [31:0] t);
      lane_out_type res;
      wide_type     acc;
      wide_type     prod;
      int           top;
      res = '0;
      top = NUM_COEFFS - 1;
      if (top < order) return res;
      acc = coef_bank[top] * falling_factor(top, order);
      for (int p = top; p > order; p--) begin
         prod = acc * t;
         // a product of magnitude 2^(62+frac) flags even when the floor lands
         // exactly on the negative bound
         if (prod >= MUL_SAT || prod <= -MUL_SAT) res.clipped = 1'b1;
         acc = prod >>> FRAC_BITS;
         if (clip_range(acc, ACC_LO, ACC_HI)) res.clipped = 1'b1;
         acc = acc + coef_bank[p-1] * falling_factor(p - 1, order);
         if (clip_range(acc, ACC_LO, ACC_HI)) res.clipped = 1'b1;
      end
      if (clip_range(acc, OUT_LO, OUT_HI)) res.clipped = 1'b1;
      res.value = acc[31:0];
      return res;
   endfunction

   function automatic motion_type predict_motion(input logic signed [31:0] t);
      motion_type   m;
      lane_out_type lane;
      logic [31:0]  vals [pec_pkg::LANES];
      m = '0;
      for (int k = 0; k < pec_pkg::LANES; k++) begin
         lane = eval_lane(k, t);
         vals[k] = lane.value;
         if (lane.clipped) m.saturated = 1'b1;
      end
      m.position     = vals[0];
      m.velocity     = vals[1];
      m.acceleration = vals[2];
      m.jerk_value   = vals[3];
      return m;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, $signed(want), $signed(got));
         mismatch_count = mismatch_count + 1;
      end
   endtask

   // counters are two-state and start at zero
   always @(posedge clock) begin : watch
      motion_type due;
      if (reset) begin
         motion_due.delete();
         for (int i = 0; i < COEF_SLOTS; i++) coef_bank[i] = '0;
         outstanding <= 0;
      end else begin
         // response side first so a stray response never eats a fresh item
         if (rsp_valid && !rsp_stall) begin
            if (motion_due.size() == 0) begin
               $error("response item with nothing expected");
               mismatch_count = mismatch_count + 1;
            end else begin
               due = motion_due.pop_front();
               check_field("position", due.position, rsp_position);
               check_field("velocity", due.velocity, rsp_velocity);
               check_field("acceleration", due.acceleration, rsp_acceleration);
               check_field("jerk_value", due.jerk_value, rsp_jerk_value);
               check_field("saturated", 32'(due.saturated), 32'(rsp_saturated));
            end
         end
         if (req_valid && !req_stall) motion_due.push_back(predict_motion(req_time_point));
         // index seven exists on the port but holds nothing
         if (csr_wr_en && csr_index < COEF_SLOTS) coef_bank[csr_index] = csr_wdata;
         outstanding <= motion_due.size();
      end
   end

endmodule

### test/testbench.sv
// Top of the polynomial evaluation unit testbench: clock, reset, stimulus and verdict.
// Depends on pec_pkg, polynomial_eval_with_derivatives_unit and motion_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_W    = pec_pkg::DATA_W;
   localparam int CSR_IDX_W = pec_pkg::CSR_IDX_W;
   localparam logic signed [DATA_W-1:0] DATA_MAX = pec_pkg::DATA_MAX;
   localparam logic signed [DATA_W-1:0] DATA_MIN = pec_pkg::DATA_MIN;

   localparam int CLK_PERIOD   = 20;
   localparam int RESET_CYCLES = 11;
   // entry reg + four stages per Horner step + output reg
   localparam int PIPE_LATENCY = 4 * (pec_pkg::NUM_COEFFS_DEF - 1) + 2;
   localparam int CSR_SLOTS    = 1 << CSR_IDX_W;
   localparam int PHASES       = 9;
   localparam int PHASE_ITEMS  = 100;
   localparam int LONG_HOLD    = 150;      // receiver hold-off, fills the pipe
   localparam int DRAIN_LIMIT  = 20000;
   localparam int LIMIT_CYCLES = 400000;

   // Q16.16 values used by the directed part
   localparam logic [DATA_W-1:0] ONE      = 32'h0001_0000;
   localparam logic [DATA_W-1:0] NEG_ONE  = 32'hFFFF_0000;
   localparam logic [DATA_W-1:0] HALF     = 32'h0000_8000;
   localparam logic [DATA_W-1:0] TWO      = 32'h0002_0000;
   localparam logic [DATA_W-1:0] LSB      = 32'h0000_0001;
   localparam logic [DATA_W-1:0] NEG_LSB  = 32'hFFFF_FFFF;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [DATA_W-1:0]   req_time_point;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [DATA_W-1:0]   rsp_position;
   logic signed [DATA_W-1:0]   rsp_velocity;
   logic signed [DATA_W-1:0]   rsp_acceleration;
   logic signed [DATA_W-1:0]   rsp_jerk_value;
   logic                       rsp_saturated;
   logic                       csr_wr_en;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [DATA_W-1:0]          csr_wdata;

   int   mismatches;
   int   outstanding;
   int   send_idle_pct;        // chance per cycle that the sender holds back
   int   rsp_idle_pct;         // chance per cycle that the receiver stalls
   logic hold_off;             // rises once to request a long receiver stall

   polynomial_eval_with_derivatives_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_time_point   (req_time_point),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_position     (rsp_position),
      .rsp_velocity     (rsp_velocity),
      .rsp_acceleration (rsp_acceleration),
      .rsp_jerk_value   (rsp_jerk_value),
      .rsp_saturated    (rsp_saturated),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   motion_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_time_point   (req_time_point),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_position     (rsp_position),
      .rsp_velocity     (rsp_velocity),
      .rsp_acceleration (rsp_acceleration),
      .rsp_jerk_value   (rsp_jerk_value),
      .rsp_saturated    (rsp_saturated),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatches),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Receiver: random stalls at the current rate; when hold_off rises, one long
   // hold so the pipeline backs up all the way to req_stall.
   initial begin
      logic hold_prev;
      hold_prev = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off && !hold_prev) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end
         hold_prev = hold_off;
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // Runaway guard; sized far beyond the slowest legal run.
   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("testbench NOT OK");
      $finish;
   end

   // Mostly small t so the sixth power stays in range, now and then the
   // full 32-bit range and the two bounds.
   function automatic logic [DATA_W-1:0] random_time();
      logic signed [DATA_W-1:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0:       ;
         1:       v = $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
         default: v = v >>> $urandom_range(10, 22);
      endcase
      return v;
   endfunction

   // Coefficients: zero now and then (lower degree), sometimes full range,
   // mostly moderate. With `extreme` set, only the two bounds.
   function automatic logic [DATA_W-1:0] random_coef(input bit extreme);
      logic signed [DATA_W-1:0] v;
      v = $urandom;
      if (extreme) return $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
      case ($urandom_range(0, 7))
         0:       v = '0;
         1:       ;
         default: v = v >>> $urandom_range(6, 20);
      endcase
      return v;
   endfunction

   // Offer one time point. Idle cycles are decided per cycle at the current
   // rate; the payload wanders while valid is low and freezes once offered.
   task automatic offer_time(input logic [DATA_W-1:0] t);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid      <= 1'b0;
         req_time_point <= $urandom;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_time_point <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop offering and wait until every response is back and the pipe is
   // quiet; coefficients may only change after this.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   // Write all seven coefficients back to back, plus junk to the unused
   // index seven, which the block must drop.
   task automatic program_coefs(input logic [DATA_W-1:0] c0, c1, c2, c3, c4, c5, c6);
      logic [DATA_W-1:0] vals [CSR_SLOTS];
      vals[0] = c0;
      vals[1] = c1;
      vals[2] = c2;
      vals[3] = c3;
      vals[4] = c4;
      vals[5] = c5;
      vals[6] = c6;
      vals[7] = $urandom;
      for (int i = 0; i < CSR_SLOTS; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int waited;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_time_point <= '0;
      csr_wr_en      <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      hold_off       <= 1'b0;
      send_idle_pct   = 25;
      rsp_idle_pct    = 65;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // coefficients straight out of reset are zero: everything reads 0
      offer_time(DATA_MAX);
      offer_time(DATA_MIN);
      settle();

      // mild mixed-sign polynomial: t = 0, +-1.0, +-lsb (floor on negatives),
      // 2.0 and the two bounds of t
      program_coefs(32'h0001_8000, 32'hFFFE_0000, 32'h0000_C000, 32'hFFFF_C000,
                    32'h0000_2000, 32'hFFFF_F000, 32'h0000_0400);
      offer_time('0);
      offer_time(ONE);
      offer_time(NEG_ONE);
      offer_time(LSB);
      offer_time(NEG_LSB);
      offer_time(TWO);
      offer_time(DATA_MAX);
      offer_time(DATA_MIN);
      settle();

      // all coefficients at the top bound: scaled sums overflow 32 bits
      program_coefs(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
      offer_time('0);
      offer_time(ONE);
      offer_time(NEG_ONE);
      offer_time(HALF);
      settle();

      // all at the bottom bound, with t at both bounds: the wide accumulator clamps
      program_coefs(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
      offer_time(ONE);
      offer_time(DATA_MIN);
      offer_time(DATA_MAX);
      settle();

      // cubic only: jerk 6 * coef_3 clips; at t = 1.0 velocity and acceleration do too
      program_coefs('0, '0, '0, DATA_MAX, '0, '0, '0);
      offer_time('0);
      offer_time(ONE);

      // --- random phases ---
      // three idle mixes, three phases each; new coefficients every phase,
      // one phase with coefficients only at the bounds
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase / 3)
            0: begin
               send_idle_pct = 25;
               rsp_idle_pct  = 65;
            end
            1: begin
               send_idle_pct = 65;
               rsp_idle_pct  = 25;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         program_coefs(random_coef(phase == 4), random_coef(phase == 4),
                       random_coef(phase == 4), random_coef(phase == 4),
                       random_coef(phase == 4), random_coef(phase == 4),
                       random_coef(phase == 4));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // full-rate sender meets a long receiver stall: pipe fills, input stalls
            if (phase == 6 && n == 20) hold_off <= 1'b1;
            offer_time(random_time());
         end
      end

      // --- drain and verdict ---
      req_valid <= 1'b0;
      @(posedge clock);
      for (waited = 0; waited < DRAIN_LIMIT && outstanding != 0; waited++)
         @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (outstanding != 0) $error("%0d expected responses never arrived", outstanding);
      if (mismatches == 0 && outstanding == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
